@@ rtl/core/bir_pkg.sv @@
// Shared constants for the bilinear image resizer: field widths, default
// sizes and configuration register indexes.
// No dependencies.
package bir_pkg;

  // Beat field widths
  localparam int COORD_W    = 10;
  localparam int SAMPLE_W   = 8;
  localparam int PIXEL_W    = 3 * SAMPLE_W;
  localparam int SIZE_REG_W = 9;
  localparam int STEP_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int WEIGHT_W   = FRAC_W + 1;
  localparam int IN_DATA_W  = 48;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  // Default geometry
  localparam int DEF_MAX_SOURCE_WIDTH  = 256;
  localparam int DEF_MAX_SOURCE_HEIGHT = 256;
  localparam int DEF_MAX_DEST_SIZE     = 1024;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COLUMN_STEP   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_STEP      = 2'd3;

  // Beat kinds carried in tuser
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

@@ rtl/core/bilinear_image_resizer.sv @@
// Top level of the bilinear image resizer: stream ports, config registers,
// frame store, read sequencer, three channel lanes and the output merge.
// Depends on bir_pkg, bir_axis_map and bir_blend_lane.
//
// Usage:
//   Input beats carry a kind in in_tuser: a store writes one RGB source pixel
//   at (column, row) into the frame store, a query names a destination pixel
//   and produces one output beat with the interpolated RGB value.
//   Stores outside the configured source size are dropped without a result.
//   A store leaves the block idle, so it is ready again on the next cycle.
//   From acceptance to out_tvalid a query passes through coordinate mapping,
//   four reads of the frame store through its one read port and read register,
//   two blend stages and one merge register. No new beat is accepted while a
//   query is in progress; the next beat is accepted on the cycle after the
//   merge register is loaded.
//   When out_tready is low, the finished result holds in the output register;
//   the block still accepts stores and starts the next query, which then waits
//   before the merge until the register is free.
//   Reset (rst_n low, synchronous) clears the control state and loads the
//   registers with 256 x 256 source size and unit steps. The frame store is
//   not cleared; read only pixels that were written. The user must write the
//   configuration (cfg_we/cfg_addr/cfg_wdata) only while idle; the block does not check it.
module bilinear_image_resizer
  import bir_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
  parameter int MAX_DEST_SIZE     = DEF_MAX_DEST_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // column[9:0], row[19:10], red_in[27:20],
                                           // green_in[35:28], blue_in[43:36], zero pad
  input  logic                  in_tuser,  // func[0]
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIXEL_W-1:0]    out_tdata, // red_out[7:0], green_out[15:8], blue_out[23:16]
  // Configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int XW    = $clog2(MAX_SOURCE_WIDTH);
  localparam int YW    = $clog2(MAX_SOURCE_HEIGHT);
  localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_RD,
    S_BL1,
    S_BL2,
    S_OUT
  } state_t;

  state_t state_r;
  logic [2:0] rd_cnt_r;
  logic       out_valid_r;
  logic [PIXEL_W-1:0] out_data_r;

  // Configuration registers
  logic [SIZE_REG_W-1:0] src_w_r, src_h_r;
  logic [STEP_W-1:0]     col_step_r, row_step_r;

  // Beat fields
  logic [COORD_W-1:0] in_col, in_row;
  logic [PIXEL_W-1:0] in_pixel;
  logic               in_beat;

  // Query registers
  logic [COORD_W-1:0] q_col_r, q_row_r;
  logic [XW-1:0]      x0_r, x1_r;
  logic [YW-1:0]      y0_r, y1_r;
  logic [FRAC_W-1:0]  fx_r, fy_r;
  logic [PIXEL_W-1:0] pix_r [4];

  // Axis map outputs
  logic [XW-1:0]     x_last, x_base, x_next;
  logic [YW-1:0]     y_last, y_base, y_next;
  logic [FRAC_W-1:0] x_frac, y_frac;

  // Frame store
  logic [PIXEL_W-1:0] mem [DEPTH];
  logic               mem_we;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [PIXEL_W-1:0] rd_data_r;
  logic [XW-1:0]      rd_x;
  logic [YW-1:0]      rd_y;
  logic [1:0]         cap_idx;

  logic [SAMPLE_W-1:0] lane_out [3];
  logic                out_free;

  assign in_col   = in_tdata[COORD_W-1:0];
  assign in_row   = in_tdata[2*COORD_W-1:COORD_W];
  assign in_pixel = in_tdata[2*COORD_W+PIXEL_W-1:2*COORD_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  // Config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r    <= SIZE_REG_W'(256);
      src_h_r    <= SIZE_REG_W'(256);
      col_step_r <= STEP_W'(65536);
      row_step_r <= STEP_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SOURCE_WIDTH:  src_w_r    <= cfg_wdata[SIZE_REG_W-1:0];
        CFG_SOURCE_HEIGHT: src_h_r    <= cfg_wdata[SIZE_REG_W-1:0];
        CFG_COLUMN_STEP:   col_step_r <= cfg_wdata[STEP_W-1:0];
        CFG_ROW_STEP:      row_step_r <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Coordinate mapping, one unit per axis
  bir_axis_map #(
    .SIZE_MAX (MAX_SOURCE_WIDTH),
    .DEST_MAX (MAX_DEST_SIZE)
  ) u_map_x (
    .coord    (q_col_r),
    .step     (col_step_r),
    .size_reg (src_w_r),
    .last     (x_last),
    .base     (x_base),
    .next     (x_next),
    .frac     (x_frac)
  );

  bir_axis_map #(
    .SIZE_MAX (MAX_SOURCE_HEIGHT),
    .DEST_MAX (MAX_DEST_SIZE)
  ) u_map_y (
    .coord    (q_row_r),
    .step     (row_step_r),
    .size_reg (src_h_r),
    .last     (y_last),
    .base     (y_base),
    .next     (y_next),
    .frac     (y_frac)
  );

  // Store beats inside the source size write the frame store
  assign mem_we  = in_beat && (in_tuser == FUNC_STORE)
                   && (32'(in_col) <= 32'(x_last))
                   && (32'(in_row) <= 32'(y_last));
  assign wr_addr = AW'(YW'(in_row) * MAX_SOURCE_WIDTH) + AW'(XW'(in_col));

  // Neighbor order: upper-left, upper-right, lower-left, lower-right
  assign rd_x    = rd_cnt_r[0] ? x1_r : x0_r;
  assign rd_y    = rd_cnt_r[1] ? y1_r : y0_r;
  assign rd_addr = AW'(rd_y * MAX_SOURCE_WIDTH) + AW'(rd_x);
  assign cap_idx = 2'(rd_cnt_r - 3'd1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_pixel;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Query payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      q_col_r <= in_col;
      q_row_r <= in_row;
    end
    if (state_r == S_MAP) begin
      x0_r <= x_base;
      x1_r <= x_next;
      fx_r <= x_frac;
      y0_r <= y_base;
      y1_r <= y_next;
      fy_r <= y_frac;
    end
    if (state_r == S_RD && rd_cnt_r != 3'd0) begin
      pix_r[cap_idx] <= rd_data_r;
    end
  end

  // Channel lanes
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    bir_blend_lane u_lane (
      .clk        (clk),
      .s00        (pix_r[0][ch*SAMPLE_W +: SAMPLE_W]),
      .s01        (pix_r[1][ch*SAMPLE_W +: SAMPLE_W]),
      .s10        (pix_r[2][ch*SAMPLE_W +: SAMPLE_W]),
      .s11        (pix_r[3][ch*SAMPLE_W +: SAMPLE_W]),
      .fx         (fx_r),
      .fy         (fy_r),
      .sample_out (lane_out[ch])
    );
  end

  assign out_free = !out_valid_r || out_tready;

  // Sequencer, read counter and output merge register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Merge register valid: load from the lanes, drop once taken
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_beat && in_tuser == FUNC_QUERY) begin
            state_r <= S_MAP;
          end
        end
        S_MAP: begin
          rd_cnt_r <= '0;
          state_r  <= S_RD;
        end
        S_RD: begin
          rd_cnt_r <= rd_cnt_r + 3'd1;
          if (rd_cnt_r == 3'd4) begin
            state_r <= S_BL1;
          end
        end
        S_BL1: state_r <= S_BL2;
        S_BL2: state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_data_r <= {lane_out[2], lane_out[1], lane_out[0]};
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_query_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_tuser == FUNC_QUERY) |=> state_r == S_MAP)
    else $error("query beat did not start mapping");

  a_store_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_tuser == FUNC_STORE) |=> state_r == S_IDLE)
    else $error("store beat left idle");

  a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result appeared outside the merge step");

  a_read_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> rd_cnt_r <= 3'd4)
    else $error("read counter out of range");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE && in_tuser == FUNC_STORE))
    else $error("frame store written outside a store beat");
`endif

endmodule

@@ rtl/core/bir_axis_map.sv @@
// Maps one destination coordinate onto the source axis: clamps the size
// register, multiplies by the Q8.16 step and splits base, neighbor, fraction.
// Depends on bir_pkg.
module bir_axis_map
  import bir_pkg::*;
#(
  parameter int SIZE_MAX = DEF_MAX_SOURCE_WIDTH,
  parameter int DEST_MAX = DEF_MAX_DEST_SIZE
) (
  input  logic [COORD_W-1:0]           coord,
  input  logic [STEP_W-1:0]            step,
  input  logic [SIZE_REG_W-1:0]        size_reg,
  output logic [$clog2(SIZE_MAX)-1:0]  last,
  output logic [$clog2(SIZE_MAX)-1:0]  base,
  output logic [$clog2(SIZE_MAX)-1:0]  next,
  output logic [FRAC_W-1:0]            frac
);

  localparam int IW = $clog2(SIZE_MAX);
  localparam int DW = $clog2(DEST_MAX);
  localparam int PW = DW + STEP_W;

  logic [DW-1:0]        coord_sat;
  logic [PW-1:0]        pos;
  logic [PW-FRAC_W-1:0] ipart;

  // Effective size minus one, size clamped to 1..SIZE_MAX
  always_comb begin
    if (size_reg == '0) begin
      last = '0;
    end else if (32'(size_reg) > 32'(SIZE_MAX)) begin
      last = IW'(SIZE_MAX - 1);
    end else begin
      last = IW'(size_reg - 1'b1);
    end
  end

  // Saturate destination coordinate
  always_comb begin
    if (32'(coord) > 32'(DEST_MAX - 1)) begin
      coord_sat = DW'(DEST_MAX - 1);
    end else begin
      coord_sat = DW'(coord);
    end
  end

  // Fixed-point position
  assign pos   = PW'(coord_sat) * PW'(step);
  assign ipart = pos[PW-1:FRAC_W];
  assign frac  = pos[FRAC_W-1:0];

  // Clamp base and right/lower neighbor to the last column or row
  always_comb begin
    if (32'(ipart) > 32'(last)) begin
      base = last;
    end else begin
      base = IW'(ipart);
    end
    if (base < last) begin
      next = base + 1'b1;
    end else begin
      next = last;
    end
  end

endmodule

@@ rtl/core/bir_blend_lane.sv @@
// One color channel of the bilinear blend: horizontal weights, then vertical
// weights, then round half up to 8 bits. Two register stages.
// Depends on bir_pkg.
module bir_blend_lane
  import bir_pkg::*;
(
  input  logic                clk,
  input  logic [SAMPLE_W-1:0] s00,
  input  logic [SAMPLE_W-1:0] s01,
  input  logic [SAMPLE_W-1:0] s10,
  input  logic [SAMPLE_W-1:0] s11,
  input  logic [FRAC_W-1:0]   fx,
  input  logic [FRAC_W-1:0]   fy,
  output logic [SAMPLE_W-1:0] sample_out
);

  localparam int TW = SAMPLE_W + FRAC_W;   // horizontal sum, max 255 << 16
  localparam int PW = TW + FRAC_W;         // vertical sum, max 255 << 32
  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(1 << FRAC_W);
  localparam logic [PW-1:0]       HALF    = PW'(64'd1 << (2 * FRAC_W - 1));

  logic [WEIGHT_W-1:0] wx0, wy0;
  logic [TW:0]         top_full, bot_full;
  logic [TW-1:0]       top_r, top_nxt, bot_r, bot_nxt;
  logic [FRAC_W-1:0]   fy_r;
  logic [PW-1:0]       pa_r, pa_nxt, pb_r, pb_nxt;
  logic [PW-1:0]       sum;

  // Stage 1: horizontal blend
  assign wx0      = ONE_Q16 - WEIGHT_W'(fx);
  assign top_full = (TW+1)'(s00 * wx0) + (TW+1)'(s01 * fx);
  assign bot_full = (TW+1)'(s10 * wx0) + (TW+1)'(s11 * fx);
  assign top_nxt  = top_full[TW-1:0];
  assign bot_nxt  = bot_full[TW-1:0];

  // Stage 2: vertical weights
  assign wy0    = ONE_Q16 - WEIGHT_W'(fy_r);
  assign pa_nxt = PW'(top_r * wy0);
  assign pb_nxt = PW'(bot_r * fy_r);

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    bot_r <= bot_nxt;
    fy_r  <= fy;
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
  end

  // Round half up; the sum never exceeds 255.5 << 32
  assign sum        = pa_r + pb_r + HALF;
  assign sample_out = sum[PW-1:PW-SAMPLE_W];

endmodule
